[design/tga_stream_decoder_unit_defines.svh]
// -----------------------------------------------------------------------------
// tga_stream_decoder_unit_defines
// Assertion macros used by the decoder unit.
// -----------------------------------------------------------------------------
`ifndef TGA_STREAM_DECODER_UNIT_DEFINES_SVH
`define TGA_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define TGA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tga decoder check failed");

// next-cycle implication
`define TGA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tga decoder check failed");

`endif

[design/tga_pkg.sv]
// -----------------------------------------------------------------------------
// tga_pkg
// Types and constants of the streaming TGA decoder.
// -----------------------------------------------------------------------------
package tga_pkg;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_ID     = 5'b00010,
      PH_MAP    = 5'b00100,
      PH_PIX    = 5'b01000,
      PH_IDLE   = 5'b10000
   } phase_type;

   localparam logic [1:0] ST_PIXEL = 2'd0;
   localparam logic [1:0] ST_UNSUP = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic [7:0] KIND_MAPPED = 8'd1;
   localparam logic [7:0] KIND_TRUE   = 8'd2;
   localparam logic [7:0] KIND_RLE    = 8'd10;

   localparam logic [15:0] HDR_ID_LEN     = 16'd0;
   localparam logic [15:0] HDR_MAP_TYPE   = 16'd1;
   localparam logic [15:0] HDR_KIND       = 16'd2;
   localparam logic [15:0] HDR_MAP_LEN_LO = 16'd5;
   localparam logic [15:0] HDR_MAP_LEN_HI = 16'd6;
   localparam logic [15:0] HDR_ENTRY_BITS = 16'd7;
   localparam logic [15:0] HDR_WIDTH_LO   = 16'd12;
   localparam logic [15:0] HDR_WIDTH_HI   = 16'd13;
   localparam logic [15:0] HDR_HEIGHT_LO  = 16'd14;
   localparam logic [15:0] HDR_HEIGHT_HI  = 16'd15;
   localparam logic [15:0] HDR_DEPTH      = 16'd16;
   localparam logic [15:0] HDR_DESC       = 16'd17;

   localparam int unsigned TOP_DOWN_BIT = 5;
   localparam logic [7:0] OPAQUE = 8'hFF;

   typedef struct packed {
      logic [31:0] color;
      logic [7:0]  repeat_res;
      logic [15:0] column;
      logic [15:0] row;
      logic        final_pixel;
      logic [1:0]  status;
   } rsp_type;

endpackage

[design/tga_if.sv]
// -----------------------------------------------------------------------------
// tga_req_if / tga_rsp_if
// Valid/ready channels for file bytes and decoded results.
// -----------------------------------------------------------------------------
interface tga_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface tga_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] color;
   logic [7:0]  repeat_res;
   logic [15:0] column;
   logic [15:0] row;
   logic        final_pixel;
   logic [1:0]  status;

   modport source (output valid, output color, output repeat_res, output column,
                   output row, output final_pixel, output status, input ready);
   modport sink (input valid, input color, input repeat_res, input column,
                 input row, input final_pixel, input status, output ready);
endinterface

[design/tga_ram.sv]
// -----------------------------------------------------------------------------
// tga_ram
// Single-port-write, single-port-read RAM with registered read data.
// -----------------------------------------------------------------------------
module tga_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tga_stream_decoder_unit.sv]
// -----------------------------------------------------------------------------
// tga_stream_decoder_unit
// Streaming TGA decoder: header, ID skip, palette load, indexed/raw/RLE pixels.
// -----------------------------------------------------------------------------
// Throughput: one file byte per cycle while the output queue has room; the palette RAM
// is read at most once per index byte. Results pass the s1 register, then a two-entry queue.
// An RLE run of more than one pixel that does not end the image divides its end position
// by the width; a pixel-completing byte arriving while that division runs waits, which
// valid files never cause. Reset clears all control state; the palette RAM is not cleared.
`include "tga_stream_decoder_unit_defines.svh"

module tga_stream_decoder_unit #(
   parameter int PALETTE_DEPTH = 256
) (
   input logic       clock,
   input logic       reset,
   tga_req_if.sink   req,
   tga_rsp_if.source rsp
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [16:0] DEPTH17 = 17'(PALETTE_DEPTH);

   tga_pkg::phase_type phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  id_len_ff, id_len_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  map_type_ff, map_type_in;
   logic [15:0] map_len_ff, map_len_in;
   logic [7:0]  entry_bits_ff, entry_bits_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  depth_ff, depth_in;
   logic        top_down_ff, top_down_in;
   logic [23:0] gather_ff, gather_in;
   logic [15:0] column_ff, column_in;
   logic [15:0] drow_ff, drow_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic        pkt_run_ff, pkt_run_in;

   logic        div_busy_ff, div_busy_in;
   logic [1:0]  div_step_ff, div_step_in;
   logic [16:0] div_rem_ff, div_rem_in;
   logic [7:0]  div_quo_ff, div_quo_in;
   logic        div_start;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_ram_ff, s1_ram_in;
   tga_pkg::rsp_type s1_data_ff, s1_data_in, s1_res;

   tga_pkg::rsp_type q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]  fifo_cnt_ff, fifo_cnt_in;
   logic [2:0]  occ;
   logic        pop;

   logic          acc;
   logic          blocked;
   logic [1:0]    px_last;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [31:0]   ram_wd, ram_q;

   tga_ram #(.WIDTH(32), .DEPTH(PALETTE_DEPTH)) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_q)
   );

   assign px_last = (depth_ff == 8'd32) ? 2'd3 : 2'd2;
   assign blocked = div_busy_ff && (phase_ff == tga_pkg::PH_PIX) &&
                    (kind_ff == tga_pkg::KIND_RLE) && (pkt_left_ff != 8'd0) &&
                    (count_ff == {14'd0, px_last});
   assign pop = (fifo_cnt_ff != 2'd0) && rsp.ready;
   assign occ = {1'b0, fifo_cnt_ff} + {2'd0, s1_valid_ff};
   assign req.ready = !blocked && (occ <= ({2'd0, pop} + 3'd1));
   assign acc = req.valid && req.ready;

   always_comb begin
      logic [7:0]  b;
      logic [8:0]  entry_bytes;
      logic [8:0]  map_last;
      logic [23:0] gnew;
      logic [31:0] entry;
      logic [15:0] col_next;
      logic        start_map, start_pix;
      logic        hdr_ok;
      logic        px_done;
      logic [31:0] px_color;
      logic        emit;
      logic [31:0] emit_color;
      logic [7:0]  emit_rep;
      logic [7:0]  rep_c;
      logic [31:0] left_sub;
      logic        fin;
      logic [16:0] total;
      logic        res_valid;
      logic        res_ram;
      tga_pkg::rsp_type res;

      b = req.data_byte;
      phase_in = phase_ff;
      count_in = count_ff;
      id_len_in = id_len_ff;
      kind_in = kind_ff;
      map_type_in = map_type_ff;
      map_len_in = map_len_ff;
      entry_bits_in = entry_bits_ff;
      width_in = width_ff;
      height_in = height_ff;
      depth_in = depth_ff;
      top_down_in = top_down_ff;
      gather_in = gather_ff;
      column_in = column_ff;
      drow_in = drow_ff;
      left_in = left_ff;
      pkt_left_in = pkt_left_ff;
      pkt_run_in = pkt_run_ff;
      div_start = 1'b0;
      rep_c = '0;
      left_sub = '0;
      fin = 1'b0;
      res_valid = 1'b0;
      res_ram = 1'b0;
      res = '0;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_wa = column_ff[AW-1:0];
      ram_ra = b[AW-1:0];
      start_map = 1'b0;
      start_pix = 1'b0;
      emit = 1'b0;
      emit_color = '0;
      emit_rep = 8'd1;
      total = '0;

      entry_bytes = ({1'b0, entry_bits_ff} + 9'd7) >> 3;
      map_last = entry_bytes - 9'd1;
      gnew = gather_ff;
      if (count_ff < 16'd3) begin
         gnew = gather_ff | ({16'd0, b} << {count_ff[1:0], 3'b000});
      end
      entry = '0;
      if (entry_bits_ff == 8'd15 || entry_bits_ff == 8'd16) begin
         entry = {tga_pkg::OPAQUE, gnew[14:10], 3'b000, gnew[9:5], 3'b000,
                  gnew[4:0], 3'b000};
      end else if (entry_bits_ff == 8'd24) begin
         entry = {tga_pkg::OPAQUE, gnew};
      end else if (entry_bits_ff == 8'd32) begin
         entry = {b, gnew};
      end
      ram_wd = entry;
      col_next = column_ff + 16'd1;
      px_done = !(count_ff < {14'd0, px_last});
      px_color = (px_last == 2'd3) ? {b, gnew} : {tga_pkg::OPAQUE, gnew};

      hdr_ok = 1'b0;
      if (kind_ff == tga_pkg::KIND_MAPPED) begin
         hdr_ok = (map_type_ff == 8'd1) && (depth_ff == 8'd8) &&
                  (entry_bits_ff == 8'd15 || entry_bits_ff == 8'd16 ||
                   entry_bits_ff == 8'd24 || entry_bits_ff == 8'd32);
      end else if (kind_ff == tga_pkg::KIND_TRUE || kind_ff == tga_pkg::KIND_RLE) begin
         hdr_ok = (depth_ff == 8'd24) || (depth_ff == 8'd32);
      end

      if (acc) begin
         unique case (phase_ff)
            tga_pkg::PH_HEADER: begin
               unique case (count_ff)
                  tga_pkg::HDR_ID_LEN:     id_len_in = b;
                  tga_pkg::HDR_MAP_TYPE:   map_type_in = b;
                  tga_pkg::HDR_KIND:       kind_in = b;
                  tga_pkg::HDR_MAP_LEN_LO: map_len_in = {map_len_ff[15:8], b};
                  tga_pkg::HDR_MAP_LEN_HI: map_len_in = {b, map_len_ff[7:0]};
                  tga_pkg::HDR_ENTRY_BITS: entry_bits_in = b;
                  tga_pkg::HDR_WIDTH_LO:   width_in = {width_ff[15:8], b};
                  tga_pkg::HDR_WIDTH_HI:   width_in = {b, width_ff[7:0]};
                  tga_pkg::HDR_HEIGHT_LO:  height_in = {height_ff[15:8], b};
                  tga_pkg::HDR_HEIGHT_HI:  height_in = {b, height_ff[7:0]};
                  tga_pkg::HDR_DEPTH:      depth_in = b;
                  tga_pkg::HDR_DESC:       top_down_in = b[tga_pkg::TOP_DOWN_BIT];
                  default: ;
               endcase
               if (count_ff < tga_pkg::HDR_DESC) begin
                  count_in = count_ff + 16'd1;
               end else begin
                  count_in = '0;
                  if (!hdr_ok) begin
                     phase_in = tga_pkg::PH_IDLE;
                     res_valid = 1'b1;
                     res.status = tga_pkg::ST_UNSUP;
                  end else if (width_ff == 16'd0 || height_ff == 16'd0) begin
                     phase_in = tga_pkg::PH_IDLE;
                     res_valid = 1'b1;
                     res.status = tga_pkg::ST_EMPTY;
                  end else if (id_len_ff != 8'd0) begin
                     phase_in = tga_pkg::PH_ID;
                  end else begin
                     start_map = 1'b1;
                  end
               end
            end
            tga_pkg::PH_ID: begin
               count_in = count_ff + 16'd1;
               if (count_in >= {8'd0, id_len_ff}) begin
                  count_in = '0;
                  start_map = 1'b1;
               end
            end
            tga_pkg::PH_MAP: begin
               gather_in = gnew;
               if (count_ff < {7'd0, map_last}) begin
                  count_in = count_ff + 16'd1;
               end else begin
                  ram_we = (kind_ff == tga_pkg::KIND_MAPPED) &&
                           ({1'b0, column_ff} < DEPTH17);
                  column_in = col_next;
                  count_in = '0;
                  gather_in = '0;
                  if (col_next == map_len_ff) begin
                     start_pix = 1'b1;
                  end
               end
            end
            tga_pkg::PH_PIX: begin
               if (kind_ff == tga_pkg::KIND_MAPPED) begin
                  emit = 1'b1;
                  res_ram = ({8'd0, b} < map_len_ff) && ({9'd0, b} < DEPTH17);
                  ram_re = res_ram;
               end else if (kind_ff == tga_pkg::KIND_TRUE) begin
                  gather_in = px_done ? 24'd0 : gnew;
                  count_in = px_done ? 16'd0 : count_ff + 16'd1;
                  emit = px_done;
                  emit_color = px_color;
               end else if (pkt_left_ff == 8'd0) begin
                  pkt_run_in = b[7];
                  pkt_left_in = {1'b0, b[6:0]} + 8'd1;
                  count_in = '0;
                  gather_in = '0;
               end else begin
                  gather_in = px_done ? 24'd0 : gnew;
                  count_in = px_done ? 16'd0 : count_ff + 16'd1;
                  emit = px_done;
                  emit_color = px_color;
                  if (px_done) begin
                     if (pkt_run_ff) begin
                        emit_rep = pkt_left_ff;
                        pkt_left_in = 8'd0;
                     end else begin
                        pkt_left_in = pkt_left_ff - 8'd1;
                     end
                  end
               end
            end
            default: phase_in = tga_pkg::PH_IDLE;
         endcase

         if (start_map) begin
            if (map_type_ff == 8'd1 && map_len_ff != 16'd0 && entry_bytes != 9'd0) begin
               phase_in = tga_pkg::PH_MAP;
               count_in = '0;
               gather_in = '0;
               column_in = '0;
            end else begin
               start_pix = 1'b1;
            end
         end
         if (start_pix) begin
            phase_in = tga_pkg::PH_PIX;
            count_in = '0;
            gather_in = '0;
            pkt_left_in = '0;
            pkt_run_in = 1'b0;
            column_in = '0;
            drow_in = '0;
            left_in = {16'd0, width_ff} * {16'd0, height_ff};
         end

         if (emit) begin
            rep_c = ({24'd0, emit_rep} > left_ff) ? left_ff[7:0] : emit_rep;
            left_sub = left_ff - {24'd0, rep_c};
            fin = (left_sub == 32'd0);
            left_in = left_sub;
            res_valid = 1'b1;
            res.color = emit_color;
            res.repeat_res = rep_c;
            res.column = column_ff;
            res.row = top_down_ff ? drow_ff : (height_ff - 16'd1 - drow_ff);
            res.final_pixel = fin;
            res.status = tga_pkg::ST_PIXEL;
            total = {1'b0, column_ff} + {9'd0, rep_c};
            if (fin) begin
               phase_in = tga_pkg::PH_IDLE;
            end else if (rep_c == 8'd1) begin
               if (total >= {1'b0, width_ff}) begin
                  column_in = 16'(total - {1'b0, width_ff});
                  drow_in = drow_ff + 16'd1;
               end else begin
                  column_in = total[15:0];
               end
            end else begin
               div_start = 1'b1;
            end
         end

         if (req.end_of_file) begin
            if (phase_in != tga_pkg::PH_IDLE) begin
               res_valid = 1'b1;
               res_ram = 1'b0;
               res = '0;
               res.status = tga_pkg::ST_TRUNC;
            end
            phase_in = tga_pkg::PH_HEADER;
            count_in = '0;
            gather_in = '0;
         end
      end

      div_busy_in = div_busy_ff;
      div_step_in = div_step_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      if (div_start) begin
         div_busy_in = 1'b1;
         div_step_in = '0;
         div_rem_in = total;
         div_quo_in = '0;
      end else if (div_busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            int k;
            logic [23:0] wk;
            k = 7 - 3 * int'(div_step_ff) - i;
            if (k >= 0) begin
               wk = {8'd0, width_ff} << k;
               if ({7'd0, div_rem_in} >= wk) begin
                  div_rem_in = 17'({7'd0, div_rem_in} - wk);
                  div_quo_in = div_quo_in | (8'd1 << k);
               end
            end
         end
         div_step_in = div_step_ff + 2'd1;
         if (div_step_ff == 2'd2) begin
            div_busy_in = 1'b0;
            column_in = div_rem_in[15:0];
            drow_in = drow_ff + {8'd0, div_quo_in};
         end
      end

      s1_valid_in = acc && res_valid;
      s1_ram_in = res_ram;
      s1_data_in = res;
   end

   always_comb begin
      s1_res = s1_data_ff;
      if (s1_ram_ff) begin
         s1_res.color = ram_q;
      end
      q0_in = q0_ff;
      q1_in = q1_ff;
      fifo_cnt_in = fifo_cnt_ff;
      if (pop) begin
         q0_in = q1_ff;
         fifo_cnt_in = fifo_cnt_in - 2'd1;
      end
      if (s1_valid_ff) begin
         if (fifo_cnt_in == 2'd0) begin
            q0_in = s1_res;
         end else begin
            q1_in = s1_res;
         end
         fifo_cnt_in = fifo_cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tga_pkg::PH_HEADER;
         count_ff <= '0;
         id_len_ff <= '0;
         kind_ff <= '0;
         map_type_ff <= '0;
         map_len_ff <= '0;
         entry_bits_ff <= '0;
         width_ff <= '0;
         height_ff <= '0;
         depth_ff <= '0;
         top_down_ff <= 1'b0;
         gather_ff <= '0;
         column_ff <= '0;
         drow_ff <= '0;
         left_ff <= '0;
         pkt_left_ff <= '0;
         pkt_run_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         div_step_ff <= '0;
         s1_valid_ff <= 1'b0;
         fifo_cnt_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         id_len_ff <= id_len_in;
         kind_ff <= kind_in;
         map_type_ff <= map_type_in;
         map_len_ff <= map_len_in;
         entry_bits_ff <= entry_bits_in;
         width_ff <= width_in;
         height_ff <= height_in;
         depth_ff <= depth_in;
         top_down_ff <= top_down_in;
         gather_ff <= gather_in;
         column_ff <= column_in;
         drow_ff <= drow_in;
         left_ff <= left_in;
         pkt_left_ff <= pkt_left_in;
         pkt_run_ff <= pkt_run_in;
         div_busy_ff <= div_busy_in;
         div_step_ff <= div_step_in;
         s1_valid_ff <= s1_valid_in;
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      s1_ram_ff <= s1_ram_in;
      s1_data_ff <= s1_data_in;
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp.valid = (fifo_cnt_ff != 2'd0);
   assign rsp.color = q0_ff.color;
   assign rsp.repeat_res = q0_ff.repeat_res;
   assign rsp.column = q0_ff.column;
   assign rsp.row = q0_ff.row;
   assign rsp.final_pixel = q0_ff.final_pixel;
   assign rsp.status = q0_ff.status;

   `TGA_ASSERT_IMP(a_queue_room, clock, reset, 1'b1, occ <= 3'd2)
   `TGA_ASSERT_IMP(a_final_is_pixel, clock, reset, rsp.valid && rsp.final_pixel,
                   rsp.status == tga_pkg::ST_PIXEL)
   `TGA_ASSERT_NXT(a_div_launch, clock, reset, div_start, div_busy_ff)

endmodule

[verif/tga_decoder_checker.sv]
// -----------------------------------------------------------------------------
// tga_decoder_checker
// Watches the byte and result channels of the TGA stream decoder, predicts
// each result from the accepted bytes and compares it field by field.
// -----------------------------------------------------------------------------
module tga_decoder_checker (
   input  logic clock,
   input  logic reset,
   tga_req_if   req,
   tga_rsp_if   rsp,
   output int   fails,
   output int   waiting,
   output int   checked
);

   tga_pkg::phase_type phase;
   logic [15:0] bcnt;
   logic [7:0]  id_len;
   logic [7:0]  kind;
   logic [7:0]  map_type;
   logic [15:0] map_len;
   logic [7:0]  entry_bits;
   logic [15:0] width;
   logic [15:0] height;
   logic [7:0]  depth;
   logic        top_down;
   logic [31:0] palette [256];
   logic [23:0] gather;
   logic [15:0] col;
   logic [15:0] drow;
   logic [31:0] left;
   logic [7:0]  pkt_left;
   logic        pkt_run;

   tga_pkg::rsp_type expected_q[$];

   function automatic int entry_bytes();
      return (int'(entry_bits) + 7) / 8;
   endfunction

   function automatic void start_pixels();
      phase = tga_pkg::PH_PIX;
      bcnt = '0;
      gather = '0;
      pkt_left = '0;
      pkt_run = 1'b0;
      col = '0;
      drow = '0;
      left = 32'(width) * 32'(height);
   endfunction

   function automatic void start_map();
      if (map_type == 8'd1 && map_len != 0 && entry_bytes() != 0) begin
         phase = tga_pkg::PH_MAP;
         bcnt = '0;
         gather = '0;
         col = '0;
      end else begin
         start_pixels();
      end
   endfunction

   function automatic bit format_ok();
      if (kind == tga_pkg::KIND_MAPPED)
         return map_type == 8'd1 && depth == 8'd8 && (entry_bits == 8'd15 ||
            entry_bits == 8'd16 || entry_bits == 8'd24 || entry_bits == 8'd32);
      if (kind == tga_pkg::KIND_TRUE || kind == tga_pkg::KIND_RLE)
         return depth == 8'd24 || depth == 8'd32;
      return 1'b0;
   endfunction

   function automatic tga_pkg::rsp_type status_rsp(logic [1:0] st);
      tga_pkg::rsp_type r;
      r = '0;
      r.status = st;
      return r;
   endfunction

   function automatic tga_pkg::rsp_type emit(logic [31:0] color, logic [31:0] rep);
      tga_pkg::rsp_type r;
      logic [31:0] total;
      if (rep > left) rep = left;
      left = left - rep;
      r.color = color;
      r.repeat_res = rep[7:0];
      r.column = col;
      r.row = top_down ? drow : 16'(height - 16'd1 - drow);
      r.final_pixel = (left == 0);
      r.status = tga_pkg::ST_PIXEL;
      total = 32'(col) + rep;
      drow = 16'(drow + total / 32'(width));
      col = 16'(total % 32'(width));
      if (left == 0) phase = tga_pkg::PH_IDLE;
      return r;
   endfunction

   function automatic bit gather_pixel(logic [7:0] b, output logic [31:0] color);
      int last;
      last = int'(depth) / 8 - 1;
      color = '0;
      if (bcnt < 3) gather = gather | (24'(b) << (8 * bcnt));
      if (int'(bcnt) < last) begin
         bcnt = bcnt + 1;
         return 1'b0;
      end
      color = (last == 3) ? {b, gather} : {tga_pkg::OPAQUE, gather};
      bcnt = '0;
      gather = '0;
      return 1'b1;
   endfunction

   function automatic bit decode_byte(logic [7:0] b, logic eof,
                                      output tga_pkg::rsp_type r);
      bit got;
      logic [31:0] color;
      logic [15:0] v;
      logic [31:0] ent;
      got = 1'b0;
      r = '0;
      color = '0;
      case (phase)
         tga_pkg::PH_HEADER: begin
            case (bcnt)
               tga_pkg::HDR_ID_LEN:     id_len = b;
               tga_pkg::HDR_MAP_TYPE:   map_type = b;
               tga_pkg::HDR_KIND:       kind = b;
               tga_pkg::HDR_MAP_LEN_LO: map_len[7:0] = b;
               tga_pkg::HDR_MAP_LEN_HI: map_len[15:8] = b;
               tga_pkg::HDR_ENTRY_BITS: entry_bits = b;
               tga_pkg::HDR_WIDTH_LO:   width[7:0] = b;
               tga_pkg::HDR_WIDTH_HI:   width[15:8] = b;
               tga_pkg::HDR_HEIGHT_LO:  height[7:0] = b;
               tga_pkg::HDR_HEIGHT_HI:  height[15:8] = b;
               tga_pkg::HDR_DEPTH:      depth = b;
               tga_pkg::HDR_DESC:       top_down = b[tga_pkg::TOP_DOWN_BIT];
               default: ;
            endcase
            if (bcnt < tga_pkg::HDR_DESC) begin
               bcnt = bcnt + 1;
            end else begin
               bcnt = '0;
               if (!format_ok()) begin
                  phase = tga_pkg::PH_IDLE;
                  r = status_rsp(tga_pkg::ST_UNSUP);
                  got = 1'b1;
               end else if (width == 0 || height == 0) begin
                  phase = tga_pkg::PH_IDLE;
                  r = status_rsp(tga_pkg::ST_EMPTY);
                  got = 1'b1;
               end else if (id_len != 0) begin
                  phase = tga_pkg::PH_ID;
               end else begin
                  start_map();
               end
            end
         end
         tga_pkg::PH_ID: begin
            bcnt = bcnt + 1;
            if (bcnt >= 16'(id_len)) begin
               bcnt = '0;
               start_map();
            end
         end
         tga_pkg::PH_MAP: begin
            if (bcnt < 3) gather = gather | (24'(b) << (8 * bcnt));
            if (int'(bcnt) < entry_bytes() - 1) begin
               bcnt = bcnt + 1;
            end else begin
               v = gather[15:0];
               ent = '0;
               if (entry_bits == 8'd15 || entry_bits == 8'd16)
                  ent = {tga_pkg::OPAQUE, v[14:10], 3'b0, v[9:5], 3'b0, v[4:0], 3'b0};
               else if (entry_bits == 8'd24)
                  ent = {tga_pkg::OPAQUE, gather};
               else if (entry_bits == 8'd32)
                  ent = {b, gather};
               if (kind == tga_pkg::KIND_MAPPED && col < 256) palette[col[7:0]] = ent;
               col = col + 1;
               bcnt = '0;
               gather = '0;
               if (col == map_len) start_pixels();
            end
         end
         tga_pkg::PH_PIX: begin
            if (kind == tga_pkg::KIND_MAPPED) begin
               if (16'(b) < map_len) color = palette[b];
               r = emit(color, 32'd1);
               got = 1'b1;
            end else if (kind == tga_pkg::KIND_TRUE) begin
               if (gather_pixel(b, color)) begin
                  r = emit(color, 32'd1);
                  got = 1'b1;
               end
            end else if (pkt_left == 0) begin
               pkt_run = b[7];
               pkt_left = {1'b0, b[6:0]} + 8'd1;
               bcnt = '0;
               gather = '0;
            end else if (gather_pixel(b, color)) begin
               if (pkt_run) begin
                  r = emit(color, 32'(pkt_left));
                  pkt_left = '0;
               end else begin
                  pkt_left = pkt_left - 1;
                  r = emit(color, 32'd1);
               end
               got = 1'b1;
            end
         end
         default: phase = tga_pkg::PH_IDLE;
      endcase
      if (eof) begin
         if (phase != tga_pkg::PH_IDLE) begin
            r = status_rsp(tga_pkg::ST_TRUNC);
            got = 1'b1;
         end
         phase = tga_pkg::PH_HEADER;
         bcnt = '0;
         gather = '0;
      end
      return got;
   endfunction

   function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fails = fails + 1;
      end
   endfunction

   assign waiting = expected_q.size();

   always @(posedge clock) begin
      tga_pkg::rsp_type exp_r;
      tga_pkg::rsp_type pred;
      if (reset) begin
         fails = 0;
         checked = 0;
         phase = tga_pkg::PH_HEADER;
         bcnt = '0; id_len = '0; kind = '0; map_type = '0; map_len = '0;
         entry_bits = '0; width = '0; height = '0; depth = '0;
         top_down = 1'b0; gather = '0; col = '0; drow = '0; left = '0;
         pkt_left = '0; pkt_run = 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            checked = checked + 1;
            if (expected_q.size() == 0) begin
               $error("result with nothing expected");
               fails = fails + 1;
            end else begin
               exp_r = expected_q.pop_front();
               compare_field("color", exp_r.color, rsp.color);
               compare_field("repeat_res", 32'(exp_r.repeat_res), 32'(rsp.repeat_res));
               compare_field("column", 32'(exp_r.column), 32'(rsp.column));
               compare_field("row", 32'(exp_r.row), 32'(rsp.row));
               compare_field("final_pixel", 32'(exp_r.final_pixel), 32'(rsp.final_pixel));
               compare_field("status", 32'(exp_r.status), 32'(rsp.status));
            end
         end
         if (req.valid && req.ready) begin
            if (decode_byte(req.data_byte, req.end_of_file, pred))
               expected_q.push_back(pred);
         end
      end
   end

endmodule

[verif/tb_top.sv]
// -----------------------------------------------------------------------------
// tb_top
// Feeds the TGA stream decoder whole, broken and noisy files byte by byte
// with bursty input and a stalling receiver; the checker judges the results.
// -----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic [7:0] b;
      logic       e;
   } file_byte_type;

   logic clock;
   logic reset;
   int   fails;
   int   waiting;
   int   checked;
   int   files_made;
   int   bytes_sent;
   bit   sent_all;
   file_byte_type byte_q[$];

   tga_req_if req ();
   tga_rsp_if rsp ();

   tga_stream_decoder_unit i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   tga_decoder_checker i_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fails(fails), .waiting(waiting), .checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic add_file(int kind, int depth, int mtype, int mlen, int ebits, int w,
                           int h, int idlen, bit topd, int cut, int extra);
      logic [7:0] f[$];
      int npix;
      int pkt;
      int bpp;
      f.push_back(8'(idlen));
      f.push_back(8'(mtype));
      f.push_back(8'(kind));
      f.push_back(8'($urandom));
      f.push_back(8'($urandom));
      f.push_back(8'(mlen));
      f.push_back(8'(mlen >> 8));
      f.push_back(8'(ebits));
      repeat (4) f.push_back(8'($urandom));
      f.push_back(8'(w));
      f.push_back(8'(w >> 8));
      f.push_back(8'(h));
      f.push_back(8'(h >> 8));
      f.push_back(8'(depth));
      f.push_back({2'($urandom), topd, 5'($urandom)});
      repeat (idlen) f.push_back(8'($urandom));
      if (mtype == 1) repeat (mlen * ((ebits + 7) / 8)) f.push_back(8'($urandom));
      npix = w * h;
      bpp = (depth == 32) ? 4 : 3;
      if (kind == tga_pkg::KIND_MAPPED) begin
         repeat (npix)
            f.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom) :
                        8'($urandom_range(0, mlen + 2)));
      end else if (kind == tga_pkg::KIND_TRUE) begin
         repeat (npix * bpp) f.push_back(8'($urandom));
      end else if (kind == tga_pkg::KIND_RLE) begin
         while (npix > 0) begin
            pkt = ($urandom_range(0, 7) == 0) ? 128 : $urandom_range(1, 12);
            if ($urandom_range(0, 1)) begin
               f.push_back({1'b1, 7'(pkt - 1)});
               repeat (bpp) f.push_back(8'($urandom));
            end else begin
               if (pkt > npix) pkt = npix;
               f.push_back({1'b0, 7'(pkt - 1)});
               repeat (pkt * bpp) f.push_back(8'($urandom));
            end
            npix = npix - pkt;
         end
      end
      repeat (extra) f.push_back(8'($urandom));
      while (cut > 0 && f.size() > 1) begin
         void'(f.pop_back());
         cut--;
      end
      foreach (f[i]) byte_q.push_back('{b: f[i], e: (i == f.size() - 1)});
      files_made++;
   endtask

   task automatic add_random_file();
      int sel;
      int kind;
      int dep;
      int eb;
      int ml;
      int cut;
      sel = $urandom_range(0, 99);
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 0;
      dep = $urandom_range(0, 1) ? 32 : 24;
      if (sel < 25) begin
         case ($urandom_range(0, 3))
            0: eb = 15;
            1: eb = 16;
            2: eb = 24;
            default: eb = 32;
         endcase
         ml = $urandom_range(0, 24);
         add_file(tga_pkg::KIND_MAPPED, 8, 1, ml, eb, $urandom_range(1, 8),
                  $urandom_range(1, 6), $urandom_range(0, 3), $urandom, cut,
                  $urandom_range(0, 2));
      end else if (sel < 75) begin
         kind = (sel < 50) ? tga_pkg::KIND_TRUE : tga_pkg::KIND_RLE;
         add_file(kind, dep, $urandom_range(0, 3) == 0, $urandom_range(0, 4),
                  $urandom_range(0, 40), $urandom_range(1, 8), $urandom_range(1, 6),
                  $urandom_range(0, 3), $urandom, cut, $urandom_range(0, 2));
      end else if (sel < 85) begin
         kind = $urandom_range(0, 255);
         add_file(kind, $urandom_range(0, 255), $urandom_range(0, 1), 0, $urandom, 0, 0,
                  0, $urandom, 0, $urandom_range(0, 8));
      end else if (sel < 90) begin
         add_file(tga_pkg::KIND_TRUE, dep, 0, 0, 0, $urandom_range(0, 1) ? 0 : $urandom,
                  0, 0, 0, 0, $urandom_range(0, 4));
      end else begin
         repeat ($urandom_range(1, 30))
            byte_q.push_back('{b: 8'($urandom), e: 1'b0});
         byte_q.push_back('{b: 8'($urandom), e: 1'b1});
      end
   endtask

   // sender: bursts with gaps
   initial begin
      int burst;
      int gap;
      file_byte_type fb;
      req.valid = 1'b0;
      req.data_byte = '0;
      req.end_of_file = 1'b0;
      reset = 1'b1;
      files_made = 0;
      sent_all = 0;
      add_file(tga_pkg::KIND_MAPPED, 8, 1, 4, 15, 2, 2, 0, 0, 0, 0);
      add_file(tga_pkg::KIND_MAPPED, 8, 1, 3, 16, 3, 1, 2, 1, 0, 1);
      add_file(tga_pkg::KIND_MAPPED, 8, 1, 5, 24, 2, 3, 0, 1, 0, 0);
      add_file(tga_pkg::KIND_MAPPED, 8, 1, 2, 32, 3, 2, 1, 0, 0, 0);
      add_file(tga_pkg::KIND_MAPPED, 8, 1, 0, 32, 2, 2, 0, 0, 0, 0);
      add_file(tga_pkg::KIND_MAPPED, 8, 1, 260, 16, 4, 4, 0, 1, 0, 0);
      add_file(tga_pkg::KIND_TRUE, 24, 0, 0, 0, 3, 2, 0, 0, 0, 0);
      add_file(tga_pkg::KIND_TRUE, 32, 1, 3, 24, 2, 2, 40, 1, 0, 0);
      add_file(tga_pkg::KIND_RLE, 24, 0, 0, 0, 5, 3, 0, 0, 0, 0);
      add_file(tga_pkg::KIND_RLE, 32, 0, 0, 0, 7, 12, 0, 1, 0, 0);
      add_file(3, 24, 0, 0, 0, 2, 2, 0, 0, 0, 0);
      add_file(tga_pkg::KIND_MAPPED, 16, 1, 4, 16, 2, 2, 0, 0, 0, 0);
      add_file(tga_pkg::KIND_MAPPED, 8, 0, 4, 16, 2, 2, 0, 0, 0, 0);
      add_file(tga_pkg::KIND_MAPPED, 8, 1, 4, 8, 2, 2, 0, 0, 0, 0);
      add_file(tga_pkg::KIND_TRUE, 16, 0, 0, 0, 2, 2, 0, 0, 0, 0);
      add_file(tga_pkg::KIND_RLE, 24, 0, 0, 0, 0, 65535, 0, 0, 0, 2);
      add_file(tga_pkg::KIND_RLE, 32, 0, 0, 0, 65535, 0, 0, 0, 0, 0);
      add_file(tga_pkg::KIND_TRUE, 32, 0, 0, 0, 65535, 65535, 0, 0, 0, 5);
      add_file(tga_pkg::KIND_TRUE, 24, 0, 0, 0, 3, 3, 0, 0, 7, 0);
      while (byte_q.size() < 1400) add_random_file();
      bytes_sent = byte_q.size();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (byte_q.size() > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && byte_q.size() > 0) begin
            fb = byte_q.pop_front();
            req.valid <= 1'b1;
            req.data_byte <= fb.b;
            req.end_of_file <= fb.e;
            @(posedge clock);
            while (!req.ready) @(posedge clock);
            burst--;
         end
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req.valid <= 1'b0;
      sent_all = 1;
   end

   // receiver: stall pattern with one long hold-off
   initial begin
      int mode;
      int cycles;
      rsp.ready = 1'b0;
      cycles = 0;
      mode = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles % 64 == 0) mode = $urandom_range(0, 2);
         if (cycles >= 900 && cycles < 1300)
            rsp.ready <= 1'b0;
         else if (mode == 0)
            rsp.ready <= 1'b1;
         else if (mode == 1)
            rsp.ready <= ($urandom_range(0, 3) != 0);
         else
            rsp.ready <= ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      wait (sent_all);
      while (waiting != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Decoded %0d files, %0d bytes sent, %0d results checked.",
               files_made, bytes_sent, checked);
      if (fails == 0 && waiting == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("Timeout with %0d results outstanding.", waiting);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
